>>> rtl/core/spfl_pkg.sv
// spfl_pkg: shared constants, codes and types of the slot pool allocator
`default_nettype none
package spfl_pkg;

  // pool geometry
  localparam int SLOT_COUNT = 64;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int LINK_W     = $clog2(SLOT_COUNT + 1);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // field widths of the transactions
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 7;
  localparam int STAT_W  = 3;
  localparam int GRANT_W = 6;
  localparam int USE_W   = 7;
  localparam int GEN_W   = 32;
  localparam int CTR_W   = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACQUIRE = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_DRAIN   = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK         = 3'd0,
    STAT_EMPTY      = 3'd1,
    STAT_SHUTDOWN   = 3'd2,
    STAT_BAD_INDEX  = 3'd3,
    STAT_NOT_USED   = 3'd4,
    STAT_DRAIN_BUSY = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } fsm_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // take the request, launch memory reads
    logic commit;   // update state, load the response register
  } ctl_t;

  typedef struct packed {
    logic               ok;
    status_e            status;
    logic [GRANT_W-1:0] granted_slot;
    logic [GEN_W-1:0]   slot_generation;
    logic [USE_W-1:0]   slots_in_use;
    logic [CTR_W-1:0]   acquire_ok_total;
    logic [CTR_W-1:0]   acquire_fail_total;
    logic [CTR_W-1:0]   release_ok_total;
    logic [CTR_W-1:0]   release_fail_total;
  } rsp_t;

  // saturating increment of a statistics counter
  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] v);
    sat_inc = (v == '1) ? v : v + CTR_W'(1);
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/spfl_req_if.sv
// spfl_req_if: request channel of the slot pool allocator
`default_nettype none
interface spfl_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [6:0] slot_index;
  logic       reopen;

  modport source (output valid, cmd, slot_index, reopen, input ready);
  modport sink   (input valid, cmd, slot_index, reopen, output ready);
endinterface
`default_nettype wire

>>> rtl/core/spfl_rsp_if.sv
// spfl_rsp_if: response channel of the slot pool allocator
`default_nettype none
interface spfl_rsp_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [2:0]  status;
  logic [5:0]  granted_slot;
  logic [31:0] slot_generation;
  logic [6:0]  slots_in_use;
  logic [31:0] acquire_ok_total;
  logic [31:0] acquire_fail_total;
  logic [31:0] release_ok_total;
  logic [31:0] release_fail_total;

  modport source (output valid, ok, status, granted_slot, slot_generation, slots_in_use,
                  acquire_ok_total, acquire_fail_total, release_ok_total,
                  release_fail_total, input ready);
  modport sink   (input valid, ok, status, granted_slot, slot_generation, slots_in_use,
                  acquire_ok_total, acquire_fail_total, release_ok_total,
                  release_fail_total, output ready);
endinterface
`default_nettype wire

>>> rtl/core/spfl_ram.sv
// spfl_ram: generic single-port ram with registered read
`default_nettype none
module spfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic                                          re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  output logic      [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/spfl_ctrl.sv
// spfl_ctrl: sequencing state machine and response valid of the allocator
`default_nettype none
module spfl_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          out_ready_i,
  output logic               out_valid_o,
  output spfl_pkg::ctl_t     ctl_o
);
  import spfl_pkg::*;

  fsm_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  // state and response valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    ctl_o       = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        ctl_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait for the response register to free up
        if (!out_valid_q || out_ready_i) begin
          ctl_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // response valid: set on commit, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  a_capture_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.capture |=> state_q == S_EXEC)
    else $error("capture did not move to exec");

  a_commit_gives_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.commit |=> out_valid_q)
    else $error("commit without a pending response");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("response overwritten before it was taken");

endmodule
`default_nettype wire

>>> rtl/core/spfl_dp.sv
// spfl_dp: free list, used bits, generations and counters of the allocator
`default_nettype none
module spfl_dp (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire spfl_pkg::ctl_t         ctl_i,
  input  wire logic [1:0]             cmd_i,
  input  wire logic [6:0]             slot_index_i,
  input  wire logic                   reopen_i,
  output spfl_pkg::rsp_t              rsp_o
);
  import spfl_pkg::*;

  // captured request
  logic [CMD_W-1:0]  cmd_q;
  logic [IDX_W-1:0]  idx_q;
  logic              reopen_q;
  logic [SLOT_W-1:0] rd_addr_q;

  // pool state
  logic [LINK_W-1:0]     head_q, head_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  shut_q, shut_d;
  logic [SLOT_COUNT-1:0] used_q, used_d;
  logic [SLOT_COUNT-1:0] link_vld_q, link_vld_d;
  logic [SLOT_COUNT-1:0] gen_vld_q, gen_vld_d;
  logic [CTR_W-1:0]      acq_ok_q, acq_ok_d, acq_fail_q, acq_fail_d;
  logic [CTR_W-1:0]      rel_ok_q, rel_ok_d, rel_fail_q, rel_fail_d;
  rsp_t                  rsp_q, rsp_d;

  // memory ports
  logic              rel_write;
  logic [SLOT_W-1:0] rd_addr, mem_addr;
  logic [LINK_W-1:0] link_rdata, link_next;
  logic [GEN_W-1:0]  gen_rdata, gen_cur, gen_inc;

  // read address: release looks at its slot, everything else at the head
  assign rd_addr  = (cmd_e'(cmd_i) == CMD_RELEASE) ? SLOT_W'(slot_index_i)
                                                    : SLOT_W'(head_q);
  assign mem_addr = ctl_i.commit ? rd_addr_q : rd_addr;

  spfl_ram #(.WIDTH(LINK_W), .DEPTH(SLOT_COUNT)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (rel_write),
    .re_i    (ctl_i.capture),
    .addr_i  (mem_addr),
    .wdata_i (head_q),
    .rdata_o (link_rdata)
  );

  spfl_ram #(.WIDTH(GEN_W), .DEPTH(SLOT_COUNT)) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (rel_write),
    .re_i    (ctl_i.capture),
    .addr_i  (mem_addr),
    .wdata_i (gen_inc),
    .rdata_o (gen_rdata)
  );

  // entries not yet written read as their reset value
  assign link_next = link_vld_q[rd_addr_q] ? link_rdata
                                           : LINK_W'(rd_addr_q) + LINK_W'(1);
  assign gen_cur   = gen_vld_q[rd_addr_q] ? gen_rdata : '0;
  assign gen_inc   = gen_cur + GEN_W'(1);

  // command execution
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    shut_d     = shut_q;
    used_d     = used_q;
    link_vld_d = link_vld_q;
    gen_vld_d  = gen_vld_q;
    acq_ok_d   = acq_ok_q;
    acq_fail_d = acq_fail_q;
    rel_ok_d   = rel_ok_q;
    rel_fail_d = rel_fail_q;
    rel_write  = 1'b0;
    rsp_d      = '0;
    rsp_d.status = STAT_OK;
    case (cmd_e'(cmd_q))
      CMD_ACQUIRE: begin
        if (shut_q) begin
          rsp_d.status = STAT_SHUTDOWN;
          acq_fail_d   = sat_inc(acq_fail_q);
        end else if (32'(head_q) >= SLOT_COUNT) begin
          rsp_d.status = STAT_EMPTY;
          acq_fail_d   = sat_inc(acq_fail_q);
        end else begin
          head_d                = link_next;
          used_d[rd_addr_q]     = 1'b1;
          count_d               = count_q + CNT_W'(1);
          rsp_d.ok              = 1'b1;
          rsp_d.granted_slot    = GRANT_W'(rd_addr_q);
          rsp_d.slot_generation = gen_cur;
          acq_ok_d              = sat_inc(acq_ok_q);
        end
      end
      CMD_RELEASE: begin
        if (32'(idx_q) >= SLOT_COUNT) begin
          rsp_d.status = STAT_BAD_INDEX;
          rel_fail_d   = sat_inc(rel_fail_q);
        end else if (!used_q[rd_addr_q]) begin
          rsp_d.status = STAT_NOT_USED;
          rel_fail_d   = sat_inc(rel_fail_q);
        end else begin
          used_d[rd_addr_q] = 1'b0;
          if (count_q != '0) begin
            count_d = count_q - CNT_W'(1);
          end
          rel_write               = ctl_i.commit;
          link_vld_d[rd_addr_q]   = 1'b1;
          gen_vld_d[rd_addr_q]    = 1'b1;
          head_d                  = LINK_W'(rd_addr_q);
          rsp_d.ok                = 1'b1;
          rsp_d.slot_generation   = gen_inc;
          rel_ok_d                = sat_inc(rel_ok_q);
        end
      end
      CMD_DRAIN: begin
        shut_d = 1'b1;
        if (count_q == '0) begin
          // rebuild: every link back to its in-order value, used bits already clear
          link_vld_d = '0;
          head_d     = '0;
          count_d    = '0;
          rsp_d.ok   = 1'b1;
        end else begin
          rsp_d.status = STAT_DRAIN_BUSY;
        end
        if (reopen_q) begin
          shut_d = 1'b0;
        end
      end
      default: ;
    endcase
    rsp_d.slots_in_use       = USE_W'(count_d);
    rsp_d.acquire_ok_total   = acq_ok_d;
    rsp_d.acquire_fail_total = acq_fail_d;
    rsp_d.release_ok_total   = rel_ok_d;
    rsp_d.release_fail_total = rel_fail_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      count_q    <= '0;
      shut_q     <= 1'b0;
      used_q     <= '0;
      link_vld_q <= '0;
      gen_vld_q  <= '0;
      acq_ok_q   <= '0;
      acq_fail_q <= '0;
      rel_ok_q   <= '0;
      rel_fail_q <= '0;
    end else if (ctl_i.commit) begin
      head_q     <= head_d;
      count_q    <= count_d;
      shut_q     <= shut_d;
      used_q     <= used_d;
      link_vld_q <= link_vld_d;
      gen_vld_q  <= gen_vld_d;
      acq_ok_q   <= acq_ok_d;
      acq_fail_q <= acq_fail_d;
      rel_ok_q   <= rel_ok_d;
      rel_fail_q <= rel_fail_d;
    end
  end

  // request capture and response register
  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      cmd_q     <= cmd_i;
      idx_q     <= slot_index_i;
      reopen_q  <= reopen_i;
      rd_addr_q <= rd_addr;
    end
    if (ctl_i.commit) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

  a_count_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'($countones(used_q)) == 32'(count_q))
    else $error("in-use count differs from used bits");

endmodule
`default_nettype wire

>>> rtl/core/slot_pool_free_list_allocator.sv
// slot_pool_free_list_allocator: top level of the slot pool allocator
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+------------------------------------------
//   req_i   | in  | valid / ready | cmd, slot_index, reopen
//   rsp_o   | out | valid / ready | ok, status, granted_slot, slot_generation,
//           |     |               | slots_in_use, four saturating totals
//
// each transaction reads the link and generation memories on capture
// (registered read), then updates the pool and loads the response register.
// drain rebuilds the list in that update by clearing per-slot link
// valid bits; there is no clearing pass after reset.
// a pending response does not block the next request; a request stalls in
// its update cycle while the previous response has not been taken.
`default_nettype none
module slot_pool_free_list_allocator (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  spfl_req_if.sink    req_i,
  spfl_rsp_if.source  rsp_o
);
  import spfl_pkg::*;

  ctl_t ctl;
  rsp_t rsp;

  // sequencing
  spfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .ctl_o       (ctl)
  );

  // pool state and response
  spfl_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .cmd_i        (req_i.cmd),
    .slot_index_i (req_i.slot_index),
    .reopen_i     (req_i.reopen),
    .rsp_o        (rsp)
  );

  // response fields
  assign rsp_o.ok                 = rsp.ok;
  assign rsp_o.status             = rsp.status;
  assign rsp_o.granted_slot       = rsp.granted_slot;
  assign rsp_o.slot_generation    = rsp.slot_generation;
  assign rsp_o.slots_in_use       = rsp.slots_in_use;
  assign rsp_o.acquire_ok_total   = rsp.acquire_ok_total;
  assign rsp_o.acquire_fail_total = rsp.acquire_fail_total;
  assign rsp_o.release_ok_total   = rsp.release_ok_total;
  assign rsp_o.release_fail_total = rsp.release_fail_total;

endmodule
`default_nettype wire

>>> verif/slot_pool_free_list_allocator_test.sv
`timescale 1ns / 100ps
// slot_pool_free_list_allocator_test: self-checking testbench of the slot pool allocator

module slot_pool_free_list_allocator_test;
  import spfl_pkg::*;

  // command code that the block leaves unassigned
  localparam logic [CMD_W-1:0] CMD_UNASSIGNED = 2'd3;

  localparam int ITEMS_TOTAL   = 1150;
  localparam int STALL_LIMIT   = 2000;
  localparam int LONG_HOLD     = 300;
  localparam int TAIL_CYCLES   = 20;
  localparam int PRINT_LIMIT   = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  spfl_req_if req_if ();
  spfl_rsp_if rsp_if ();

  slot_pool_free_list_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #6 clk_i = ~clk_i;

  // shadow copy of the pool
  int               pool_link [SLOT_COUNT];
  bit               pool_held [SLOT_COUNT];
  logic [GEN_W-1:0] pool_gen  [SLOT_COUNT];
  int               pool_head;
  int               pool_in_use;
  bit               pool_closing;
  logic [CTR_W-1:0] acq_ok_n, acq_fail_n, rel_ok_n, rel_fail_n;

  // outcomes predicted for accepted commands, oldest first
  rsp_t awaited_outcomes[$];

  // run statistics
  int items_sent = 0;
  int outcomes_checked = 0;
  int mismatches = 0;
  int n_acquire = 0, n_release = 0, n_drain = 0, n_unassigned = 0;
  int n_ran_dry = 0, n_rebuilt = 0;

  // idling controls shared by the tests and the response sink
  bit send_gaps = 1'b1;
  bit recv_stalls = 1'b1;
  int rsp_hold_cycles = 0;
  int quiet_cycles = 0;

  function automatic logic [CTR_W-1:0] bump(input logic [CTR_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // free list back in order 0..N-1, nothing in use
  function automatic void relink_pool();
    for (int i = 0; i < SLOT_COUNT; i++) begin
      pool_link[i] = i + 1;
      pool_held[i] = 1'b0;
    end
    pool_head = 0;
    pool_in_use = 0;
  endfunction

  function automatic void clear_pool_model();
    relink_pool();
    for (int i = 0; i < SLOT_COUNT; i++) pool_gen[i] = '0;
    pool_closing = 1'b0;
    acq_ok_n = '0;
    acq_fail_n = '0;
    rel_ok_n = '0;
    rel_fail_n = '0;
  endfunction

  // apply one command to the shadow pool and return the response it yields
  function automatic rsp_t predict_pool_outcome(input logic [CMD_W-1:0] c,
                                                input logic [IDX_W-1:0] idx,
                                                input logic r);
    rsp_t o;
    int s;
    o = '0;
    o.status = STAT_OK;
    case (c)
      CMD_ACQUIRE: begin
        n_acquire++;
        // shutdown is checked before emptiness
        if (pool_closing) begin
          o.status = STAT_SHUTDOWN;
          acq_fail_n = bump(acq_fail_n);
        end else if (pool_head >= SLOT_COUNT) begin
          o.status = STAT_EMPTY;
          acq_fail_n = bump(acq_fail_n);
          n_ran_dry++;
        end else begin
          s = pool_head;
          pool_head = pool_link[s];
          pool_held[s] = 1'b1;
          pool_in_use++;
          o.ok = 1'b1;
          o.granted_slot = GRANT_W'(s);
          o.slot_generation = pool_gen[s];
          acq_ok_n = bump(acq_ok_n);
        end
      end
      CMD_RELEASE: begin
        n_release++;
        if (int'(idx) >= SLOT_COUNT) begin
          o.status = STAT_BAD_INDEX;
          rel_fail_n = bump(rel_fail_n);
        end else if (!pool_held[idx]) begin
          o.status = STAT_NOT_USED;
          rel_fail_n = bump(rel_fail_n);
        end else begin
          pool_held[idx] = 1'b0;
          if (pool_in_use > 0) pool_in_use--;
          pool_gen[idx] = pool_gen[idx] + 1'b1;
          pool_link[idx] = pool_head;
          pool_head = idx;
          o.ok = 1'b1;
          o.slot_generation = pool_gen[idx];
          rel_ok_n = bump(rel_ok_n);
        end
      end
      CMD_DRAIN: begin
        n_drain++;
        pool_closing = 1'b1;
        if (pool_in_use == 0) begin
          relink_pool();
          o.ok = 1'b1;
          n_rebuilt++;
        end else begin
          o.status = STAT_DRAIN_BUSY;
        end
        if (r) pool_closing = 1'b0;
      end
      default: begin
        // unassigned command leaves the pool alone
        n_unassigned++;
      end
    endcase
    o.slots_in_use = USE_W'(pool_in_use);
    o.acquire_ok_total = acq_ok_n;
    o.acquire_fail_total = acq_fail_n;
    o.release_ok_total = rel_ok_n;
    o.release_fail_total = rel_fail_n;
    return o;
  endfunction

  // a slot currently held, scanned from a random start, or -1
  function automatic int pick_held_slot();
    int start;
    start = $urandom_range(0, SLOT_COUNT - 1);
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (pool_held[(start + k) % SLOT_COUNT]) return (start + k) % SLOT_COUNT;
    end
    return -1;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_LIMIT)
      $display("[%0t] mismatch on result %0d: %s", $time, outcomes_checked, what);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // offer one command and wait until the block takes it
  task automatic send_item(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx,
                           input logic r);
    int gap;
    gap = send_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.cmd        <= c;
    req_if.slot_index <= idx;
    req_if.reopen     <= r;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    awaited_outcomes.push_back(predict_pool_outcome(c, idx, r));
    items_sent++;
  endtask

  task automatic send_noise();
    send_item(CMD_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 127)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic release_all_held();
    int s;
    s = pick_held_slot();
    while (s >= 0) begin
      send_item(CMD_RELEASE, IDX_W'(s), 1'($urandom));
      s = pick_held_slot();
    end
  endtask

  // stop offering and wait for every outstanding response
  task automatic settle();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (awaited_outcomes.size() != 0);
  endtask

  // field extremes, every command and every error path except an empty pool
  task automatic test_directed();
    send_item(CMD_ACQUIRE, 7'd0, 1'b0);
    send_item(CMD_ACQUIRE, 7'd127, 1'b1);
    send_item(CMD_RELEASE, 7'd1, 1'b0);
    send_item(CMD_ACQUIRE, 7'd0, 1'b0);     // lifo: same slot, new generation
    send_item(CMD_RELEASE, 7'd127, 1'b0);   // index out of range
    send_item(CMD_RELEASE, 7'd64, 1'b1);    // first index past the pool
    send_item(CMD_RELEASE, 7'd63, 1'b0);    // slot never handed out
    send_item(CMD_UNASSIGNED, 7'd127, 1'b1);
    send_item(CMD_DRAIN, 7'd0, 1'b0);       // slots in use, stays shut
    send_item(CMD_ACQUIRE, 7'd0, 1'b0);     // refused while shut
    send_item(CMD_RELEASE, 7'd0, 1'b0);     // release still works while shut
    send_item(CMD_RELEASE, 7'd0, 1'b1);     // double release
    send_item(CMD_RELEASE, 7'd1, 1'b0);
    send_item(CMD_DRAIN, 7'd127, 1'b0);     // completes, stays shut
    send_item(CMD_ACQUIRE, 7'd63, 1'b1);
    send_item(CMD_DRAIN, 7'd0, 1'b1);       // completes and reopens
    send_item(CMD_ACQUIRE, 7'd0, 1'b0);     // generations survive the rebuild
    send_item(CMD_ACQUIRE, 7'd0, 1'b0);
    send_item(CMD_DRAIN, 7'd0, 1'b1);       // busy, but reopen still clears
    send_item(CMD_ACQUIRE, 7'd0, 1'b0);
    send_item(CMD_UNASSIGNED, 7'd0, 1'b0);
    release_all_held();
  endtask

  // take every slot, run dry, give all back, no idling on either side
  task automatic test_pool_exhaustion();
    send_gaps = 1'b0;
    recv_stalls = 1'b0;
    release_all_held();
    send_item(CMD_DRAIN, IDX_W'($urandom), 1'b1);
    repeat (SLOT_COUNT + 2) send_item(CMD_ACQUIRE, IDX_W'($urandom), 1'($urandom));
    release_all_held();
    send_item(CMD_DRAIN, IDX_W'($urandom), 1'b0);
    send_item(CMD_ACQUIRE, IDX_W'($urandom), 1'($urandom));
    send_item(CMD_DRAIN, IDX_W'($urandom), 1'b1);
    settle();
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
  endtask

  // response side holds off long enough for the request side to stall
  task automatic test_backpressure();
    int s;
    send_gaps = 1'b0;
    rsp_hold_cycles = LONG_HOLD;
    repeat (24) begin
      s = pick_held_slot();
      if (s >= 0 && $urandom_range(0, 1) == 0)
        send_item(CMD_RELEASE, IDX_W'(s), 1'($urandom));
      else
        send_item(CMD_ACQUIRE, IDX_W'($urandom), 1'($urandom));
    end
    settle();
    send_gaps = 1'b1;
  endtask

  // open / use / give back / drain lifecycles mixed with noise bursts
  task automatic test_random_traffic();
    int steps;
    int s;
    while (items_sent < ITEMS_TOTAL) begin
      send_gaps = ($urandom_range(0, 3) != 0);
      recv_stalls = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 10)) send_noise();
      end else begin
        send_item(CMD_DRAIN, IDX_W'($urandom), 1'b1);
        steps = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 160)
                                            : $urandom_range(4, 40);
        // keep the last lifecycle within the item budget
        if (steps > ITEMS_TOTAL - items_sent)
          steps = (ITEMS_TOTAL > items_sent) ? ITEMS_TOTAL - items_sent : 0;
        repeat (steps) begin
          s = pick_held_slot();
          if ($urandom_range(0, 19) == 0)
            send_noise();
          else if (s >= 0 && $urandom_range(0, 3) == 0)
            send_item(CMD_RELEASE, IDX_W'(s), 1'($urandom));
          else
            send_item(CMD_ACQUIRE, IDX_W'($urandom), 1'($urandom));
        end
        release_all_held();
        send_item(CMD_DRAIN, IDX_W'($urandom), 1'($urandom_range(0, 4) != 0));
      end
    end
    send_gaps = 1'b1;
    recv_stalls = 1'b1;
  endtask

  // response sink with random stalls and an occasional long hold
  initial begin : rsp_sink
    int stall;
    rsp_if.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (rsp_hold_cycles > 0) begin
        stall = rsp_hold_cycles;
        rsp_hold_cycles = 0;
      end else begin
        stall = recv_stalls ? $urandom_range(0, 9) : 0;
      end
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
    end
  end

  // compare each accepted response with the oldest prediction
  always @(posedge clk_i) begin : outcome_check
    rsp_t want;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("response with no command outstanding");
      end else begin
        want = awaited_outcomes.pop_front();
        compare_field("ok", rsp_if.ok, want.ok);
        compare_field("status", rsp_if.status, want.status);
        compare_field("granted_slot", rsp_if.granted_slot, want.granted_slot);
        compare_field("slot_generation", rsp_if.slot_generation, want.slot_generation);
        compare_field("slots_in_use", rsp_if.slots_in_use, want.slots_in_use);
        compare_field("acquire_ok_total", rsp_if.acquire_ok_total, want.acquire_ok_total);
        compare_field("acquire_fail_total", rsp_if.acquire_fail_total,
                      want.acquire_fail_total);
        compare_field("release_ok_total", rsp_if.release_ok_total, want.release_ok_total);
        compare_field("release_fail_total", rsp_if.release_fail_total,
                      want.release_fail_total);
      end
      outcomes_checked++;
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) === 1'b1 || (rsp_if.valid && rsp_if.ready) === 1'b1)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d responses outstanding",
               quiet_cycles, awaited_outcomes.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni            <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.cmd        <= CMD_ACQUIRE;
    req_if.slot_index <= '0;
    req_if.reopen     <= 1'b0;
    clear_pool_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    settle();
    test_pool_exhaustion();
    test_backpressure();
    test_random_traffic();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (awaited_outcomes.size() != 0)
      report_mismatch($sformatf("%0d responses never arrived", awaited_outcomes.size()));

    $display("covered %0d commands: %0d acquire, %0d release, %0d drain, %0d unassigned",
             items_sent, n_acquire, n_release, n_drain, n_unassigned);
    $display("pool ran dry %0d times, %0d drains rebuilt the list, %0d responses checked",
             n_ran_dry, n_rebuilt, outcomes_checked);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
